// File: sv/rrb_pkg.sv
// Shared types and constants for the response reorder buffer.
// No dependencies; imported by rrb_store and response_reorder_buffer_core.
package rrb_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned TAG_W      = 4;
  localparam int unsigned PAYLOAD_W  = 64;
  localparam int unsigned OCC_W      = $clog2(DEPTH) + 1;
  localparam int unsigned IN_DATA_W  = 72;  // 71 used bits, padded to bytes
  localparam int unsigned OUT_DATA_W = 72;  // 69 used bits, padded to bytes

  typedef logic [TAG_W-1:0] tag_t;
  typedef logic [OCC_W-1:0] occ_t;

  // One stored response: data word plus its null marker.
  typedef struct packed {
    logic                 is_null;
    logic [PAYLOAD_W-1:0] data;
  } entry_t;

  typedef enum logic {
    CMD_CREATE = 1'b0,
    CMD_RESP   = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_GRANT = 2'd0,
    KIND_NOTAG = 2'd1,
    KIND_RESP  = 2'd2,
    KIND_FULL  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } state_e;

endpackage

// File: sv/rrb_store.sv
// Response data store: one write port, one read port, registered read data.
// Depends on rrb_pkg for depth and entry layout.
module rrb_store (
  input  logic           clk_i,
  input  logic           we_i,
  input  rrb_pkg::tag_t  waddr_i,
  input  rrb_pkg::entry_t wdata_i,
  input  rrb_pkg::tag_t  raddr_i,
  output rrb_pkg::entry_t rdata_o
);
  import rrb_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/response_reorder_buffer_core.sv
// Response reorder buffer: hands out sequence tags and returns responses in request order.
// Depends on rrb_pkg and rrb_store.
// A create or pass-through request gives its result in the cycle after acceptance.
// A response that completes the head starts a drain: a read state (ST_READ), then one result
// per cycle while the output is free, from the data store's registered read port; the request
// after it waits for the drain. One request is accepted every cycle while the output is free.
// Reset (rst_ni, async, active low): all tags free, head/tail/occupancy zero, output empty.
module response_reorder_buffer_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Request side
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [0] is_query, [4:1] tag, [5] tag_valid, [69:6] payload, [70] payload_null, [71] zero
  input  logic [rrb_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // [0] command
  input  logic                           s_axis_tuser_i,
  // Result side
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [3:0] tag_out, [67:4] payload_out, [68] payload_null_out, [71:69] zero
  output logic [rrb_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  // [1:0] result_kind
  output logic [1:0]                     m_axis_tuser_o,
  output logic                           m_axis_tlast_o
);
  import rrb_pkg::*;

  // ---------------------------------------------------------------------------
  // Request field decode
  // ---------------------------------------------------------------------------
  cmd_e                 in_cmd;
  logic                 in_is_query;
  tag_t                 in_tag;
  logic                 in_tag_valid;
  logic [PAYLOAD_W-1:0] in_payload;
  logic                 in_null;

  assign in_cmd       = cmd_e'(s_axis_tuser_i);
  assign in_is_query  = s_axis_tdata_i[0];
  assign in_tag       = s_axis_tdata_i[TAG_W:1];
  assign in_tag_valid = s_axis_tdata_i[TAG_W+1];
  assign in_payload   = s_axis_tdata_i[TAG_W+2 +: PAYLOAD_W];
  assign in_null      = s_axis_tdata_i[TAG_W+2+PAYLOAD_W];

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  state_e           state_q, state_d;
  logic [DEPTH-1:0] pend_q, pend_d;    // tag handed out, response not yet in
  logic [DEPTH-1:0] fin_q, fin_d;      // response in, waiting to drain
  tag_t             head_q, head_d;
  tag_t             tail_q, tail_d;
  occ_t             occ_q, occ_d;

  // Output register
  logic                 ovalid_q, ovalid_d;
  kind_e                okind_q, okind_d;
  tag_t                 otag_q, otag_d;
  logic [PAYLOAD_W-1:0] odata_q, odata_d;
  logic                 onull_q, onull_d;
  logic                 olast_q, olast_d;

  // Data store port
  logic   st_we;
  entry_t st_wdata;
  tag_t   st_raddr;
  entry_t st_rdata;

  logic out_free;
  logic in_fire;
  logic resp_hit;
  logic full;
  tag_t head_nxt;
  tag_t tail_nxt;
  logic drain_last;

  // The output slot takes a new result when empty or being drained this cycle.
  assign out_free = !ovalid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && out_free;
  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;

  assign resp_hit = in_tag_valid && pend_q[in_tag];
  assign full     = (occ_q == occ_t'(DEPTH));
  assign head_nxt = (head_q == tag_t'(DEPTH - 1)) ? '0 : head_q + tag_t'(1);
  assign tail_nxt = (tail_q == tag_t'(DEPTH - 1)) ? '0 : tail_q + tag_t'(1);

  // Drain stops after the head if the next entry is still outstanding or the buffer empties.
  assign drain_last = !fin_q[head_nxt] || (occ_q == occ_t'(1));

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && in_cmd == CMD_RESP && resp_hit && in_tag == head_q) begin
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free && drain_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath and bookkeeping
  // ---------------------------------------------------------------------------
  always_comb begin
    pend_d   = pend_q;
    fin_d    = fin_q;
    head_d   = head_q;
    tail_d   = tail_q;
    occ_d    = occ_q;
    ovalid_d = ovalid_q && !m_axis_tready_i;
    okind_d  = okind_q;
    otag_d   = otag_q;
    odata_d  = odata_q;
    onull_d  = onull_q;
    olast_d  = olast_q;
    st_we    = 1'b0;
    st_wdata = '{is_null: in_null, data: in_payload};
    st_raddr = head_q;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_cmd == CMD_CREATE) begin
            ovalid_d = 1'b1;
            otag_d   = '0;
            odata_d  = '0;
            onull_d  = 1'b0;
            olast_d  = 1'b1;
            if (!in_is_query) begin
              okind_d = KIND_NOTAG;
            end else if (full) begin
              okind_d = KIND_FULL;
            end else begin
              okind_d        = KIND_GRANT;
              otag_d         = tail_q;
              pend_d[tail_q] = 1'b1;
              fin_d[tail_q]  = 1'b0;
              tail_d         = tail_nxt;
              occ_d          = occ_q + occ_t'(1);
            end
          end else if (!resp_hit) begin
            // Unknown, free or already finished tag: pass straight through.
            ovalid_d = 1'b1;
            okind_d  = KIND_RESP;
            otag_d   = in_tag;
            odata_d  = in_payload;
            onull_d  = in_null;
            olast_d  = 1'b1;
          end else begin
            st_we          = 1'b1;
            pend_d[in_tag] = 1'b0;
            fin_d[in_tag]  = 1'b1;
          end
        end
      end
      ST_READ: begin
        st_raddr = head_q;
      end
      ST_EMIT: begin
        if (out_free) begin
          ovalid_d      = 1'b1;
          okind_d       = KIND_RESP;
          otag_d        = head_q;
          odata_d       = st_rdata.data;
          onull_d       = st_rdata.is_null;
          olast_d       = drain_last;
          fin_d[head_q] = 1'b0;
          head_d        = head_nxt;
          occ_d         = occ_q - occ_t'(1);
          st_raddr      = head_nxt;  // prefetch the next entry
        end
      end
      default: ;
    endcase
  end

  rrb_store u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (in_tag),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      pend_q   <= '0;
      fin_q    <= '0;
      head_q   <= '0;
      tail_q   <= '0;
      occ_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      pend_q   <= pend_d;
      fin_q    <= fin_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      occ_q    <= occ_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    okind_q <= okind_d;
    otag_q  <= otag_d;
    odata_q <= odata_d;
    onull_q <= onull_d;
    olast_q <= olast_d;
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {{(OUT_DATA_W - TAG_W - PAYLOAD_W - 1){1'b0}},
                            onull_q, odata_q, otag_q};
  assign m_axis_tuser_o  = okind_q;
  assign m_axis_tlast_o  = olast_q;

endmodule

// File: dv/response_reorder_buffer_core_tb.sv
// Self-checking testbench for response_reorder_buffer_core: directed and random request
// streams with random idling on both sides, results checked in order against a predictor.
// Depends on rrb_pkg and the RTL of response_reorder_buffer_core.
module response_reorder_buffer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rrb_pkg::*;

  localparam int unsigned RESET_CYCLES = 7;
  localparam int unsigned RAND_REQS    = 127;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct packed {
    cmd_e                 cmd;
    logic                 is_query;
    tag_t                 tag;
    logic                 tag_valid;
    logic [PAYLOAD_W-1:0] payload;
    logic                 payload_null;
  } req_t;

  typedef struct packed {
    kind_e                kind;
    tag_t                 tag;
    logic [PAYLOAD_W-1:0] data;
    logic                 is_null;
    logic                 last;
  } rsp_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [1:0]            m_axis_tuser;
  logic                  m_axis_tlast;

  response_reorder_buffer_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  req_t req_q[$];       // requests waiting to be driven
  rsp_t results_due[$]; // results the buffer still owes, oldest first

  int unsigned mismatches;
  int unsigned n_reqs, n_results, n_grants, n_full, n_bypass, n_held, longest_drain;

  // ---------------------------------------------------------------------------
  // Predictor: tag ring with pending / finished flags and stored responses
  // ---------------------------------------------------------------------------
  bit                   ring_pending [DEPTH];
  bit                   ring_done    [DEPTH];
  logic [PAYLOAD_W-1:0] ring_data    [DEPTH];
  bit                   ring_null    [DEPTH];
  tag_t                 ring_head, ring_tail;
  int unsigned          ring_occ;

  function automatic rsp_t blank_rsp(kind_e k);
    rsp_t e;
    e      = '0;
    e.kind = k;
    e.last = 1'b1;
    return e;
  endfunction

  function automatic void predict_results(req_t r);
    rsp_t e;
    rsp_t burst[$];
    n_reqs++;
    if (r.cmd == CMD_CREATE) begin
      if (!r.is_query) begin
        results_due.push_back(blank_rsp(KIND_NOTAG));
      end else if (ring_occ >= DEPTH) begin
        n_full++;
        results_due.push_back(blank_rsp(KIND_FULL));
      end else begin
        e     = blank_rsp(KIND_GRANT);
        e.tag = ring_tail;
        ring_pending[ring_tail] = 1'b1;
        ring_done[ring_tail]    = 1'b0;
        ring_tail = tag_t'((ring_tail + 1) % DEPTH);
        ring_occ++;
        n_grants++;
        results_due.push_back(e);
      end
      return;
    end
    // invalid or non-pending tag: echo the response as is
    if (!r.tag_valid || !ring_pending[r.tag]) begin
      e         = blank_rsp(KIND_RESP);
      e.tag     = r.tag;
      e.data    = r.payload;
      e.is_null = r.payload_null;
      n_bypass++;
      results_due.push_back(e);
      return;
    end
    ring_pending[r.tag] = 1'b0;
    ring_done[r.tag]    = 1'b1;
    ring_data[r.tag]    = r.payload;
    ring_null[r.tag]    = r.payload_null;
    while (ring_occ > 0 && ring_done[ring_head] && burst.size() < DEPTH) begin
      e         = blank_rsp(KIND_RESP);
      e.tag     = ring_head;
      e.data    = ring_data[ring_head];
      e.is_null = ring_null[ring_head];
      e.last    = 1'b0;
      burst.push_back(e);
      ring_done[ring_head] = 1'b0;
      ring_head = tag_t'((ring_head + 1) % DEPTH);
      ring_occ--;
    end
    if (burst.size() == 0) begin
      n_held++;  // completed out of order, parked until the head finishes
    end else begin
      burst[burst.size()-1].last = 1'b1;
      if (burst.size() > longest_drain) longest_drain = burst.size();
      foreach (burst[i]) results_due.push_back(burst[i]);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus planning: a light shadow of the ring so responses hit live tags
  // ---------------------------------------------------------------------------
  bit          plan_pending [DEPTH];
  tag_t        plan_head, plan_tail;
  int unsigned plan_occ;

  task automatic plan_create(input bit query);
    req_t r;
    r.cmd          = CMD_CREATE;
    r.is_query     = query;
    r.tag          = tag_t'($urandom_range(0, DEPTH - 1));
    r.tag_valid    = 1'($urandom_range(0, 1));
    r.payload      = {$urandom, $urandom};
    r.payload_null = 1'($urandom_range(0, 1));
    req_q.push_back(r);
    if (query && plan_occ < DEPTH) begin
      plan_pending[plan_tail] = 1'b1;
      plan_tail = tag_t'((plan_tail + 1) % DEPTH);
      plan_occ++;
    end
  endtask

  task automatic plan_response(input tag_t t, input bit valid, input logic [PAYLOAD_W-1:0] p,
                               input bit nul);
    req_t r;
    r.cmd          = CMD_RESP;
    r.is_query     = 1'($urandom_range(0, 1));
    r.tag          = t;
    r.tag_valid    = valid;
    r.payload      = p;
    r.payload_null = nul;
    req_q.push_back(r);
    if (valid && plan_pending[t]) begin
      plan_pending[t] = 1'b0;
      while (plan_occ > 0 && !plan_pending[plan_head]) begin
        plan_head = tag_t'((plan_head + 1) % DEPTH);
        plan_occ--;
      end
    end
  endtask

  function automatic void open_tags(output tag_t tags[$]);
    tag_t t;
    tags = {};
    for (int i = 0; i < plan_occ; i++) begin
      t = tag_t'((plan_head + i) % DEPTH);
      if (plan_pending[t]) tags.push_back(t);
    end
  endfunction

  task automatic plan_random();
    tag_t        tags[$];
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      // fill to the brim, bounce once off the full flag, answer newest first
      while (plan_occ < DEPTH) plan_create(1'b1);
      plan_create(1'b1);
      open_tags(tags);
      for (int i = tags.size() - 1; i >= 0; i--)
        plan_response(tags[i], 1'b1, {$urandom, $urandom}, 1'($urandom_range(0, 1)));
    end else if (pick < 40) begin
      plan_create(1'b1);
    end else if (pick < 48) begin
      plan_create(1'b0);
    end else if (pick < 87) begin
      open_tags(tags);
      if (tags.size() == 0) plan_create(1'b1);
      else plan_response(tags[$urandom_range(0, tags.size() - 1)], 1'b1,
                         {$urandom, $urandom}, 1'($urandom_range(0, 1)));
    end else begin
      // random response: a random tag, flagged valid about half the time
      plan_response(tag_t'($urandom_range(0, DEPTH - 1)), 1'($urandom_range(0, 1)),
                    {$urandom, $urandom}, 1'($urandom_range(0, 1)));
    end
  endtask

  // idle draw: occasional stretches with no idling at all
  function automatic int unsigned draw_wait(inout bit busy_run);
    if ($urandom_range(0, 19) == 0) busy_run = !busy_run;
    return busy_run ? 0 : $urandom_range(0, 13);
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------
  req_t        cur_req;
  int unsigned req_gap;
  bit          req_busy_run;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      req_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_results(cur_req);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (req_gap > 0) begin
          req_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (req_q.size() > 0) begin
          cur_req = req_q.pop_front();
          s_axis_tdata  <= {1'b0, cur_req.payload_null, cur_req.payload, cur_req.tag_valid,
                            cur_req.tag, cur_req.is_query};
          s_axis_tuser  <= cur_req.cmd;
          s_axis_tvalid <= 1'b1;
          req_gap = draw_wait(req_busy_run);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor and checker
  // ---------------------------------------------------------------------------
  int unsigned rsp_stall;
  bit          rsp_busy_run;

  always @(posedge clk_i) begin
    rsp_t got, want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rsp_stall = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        got.kind    = kind_e'(m_axis_tuser);
        got.tag     = m_axis_tdata[3:0];
        got.data    = m_axis_tdata[67:4];
        got.is_null = m_axis_tdata[68];
        got.last    = m_axis_tlast;
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("[%0t] unexpected result: kind=%s tag=%0d data=%h null=%b last=%b",
                     $realtime, got.kind.name(), got.tag, got.data, got.is_null, got.last);
        end else begin
          want = results_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("[%0t] result mismatch:", $realtime);
              $display("  expected kind=%s tag=%0d data=%h null=%b last=%b",
                       want.kind.name(), want.tag, want.data, want.is_null, want.last);
              $display("  actual   kind=%s tag=%0d data=%h null=%b last=%b",
                       got.kind.name(), got.tag, got.data, got.is_null, got.last);
            end
          end
        end
        rsp_stall = draw_wait(rsp_busy_run);
      end
      if (rsp_stall > 0) begin
        rsp_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog: too long without a handshake on either side
  int unsigned idle_cycles;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("Timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
          $display("Verification failed");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    ring_head     = '0;
    ring_tail     = '0;
    plan_head     = '0;
    plan_tail     = '0;

    // directed: no-tag create, fill the ring, full rejection
    plan_create(1'b0);
    repeat (DEPTH) plan_create(1'b1);
    plan_create(1'b1);
    // untagged response with all-ones data, echoed straight back
    plan_response(tag_t'(DEPTH - 1), 1'b0, '1, 1'b1);
    // tag 2 finishes early and is held; a repeat of it is no longer pending
    plan_response(tag_t'(2), 1'b1, {$urandom, $urandom}, 1'b0);
    plan_response(tag_t'(2), 1'b1, '1, 1'b1);
    // head completes alone (tag 1 still open), then tag 1 releases 1 and 2
    plan_response(tag_t'(0), 1'b1, '0, 1'b0);
    plan_response(tag_t'(1), 1'b1, '1, 1'b1);

    while (req_q.size() < 23 + RAND_REQS) plan_random();

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (req_q.size() > 0 || s_axis_tvalid) @(posedge clk_i);
    while (results_due.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Requests: %0d (%0d tags granted, %0d full rejections, %0d echoed, %0d held)",
             n_reqs, n_grants, n_full, n_bypass, n_held);
    $display("Results checked: %0d, longest in-order drain: %0d, mismatches: %0d",
             n_results, longest_drain, mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
